>>> rtl/core/ttacc_pkg.sv
`timescale 1ns / 1ps
// Package for the triangle tangent accumulator: payload structs, constants,
// datapath command and status types. No dependencies.
package ttacc_pkg;

	localparam int DEF_MAX_VERTICES = 65536;
	localparam int DIV_STEPS = 81;
	localparam int SQRT_STEPS = 32;
	localparam logic signed [31:0] DELTA_LIMIT = 32'sd2147483647;

	typedef struct packed {
		logic [15:0] vertex_index;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] tex_u;
		logic signed [31:0] tex_v;
	} corner_t;

	typedef struct packed {
		logic [15:0] out_index;
		logic signed [15:0] tangent_x;
		logic signed [15:0] tangent_y;
		logic signed [15:0] tangent_z;
		logic signed [15:0] bitangent_x;
		logic signed [15:0] bitangent_y;
		logic signed [15:0] bitangent_z;
		logic degenerate;
		logic last_of_face;
	} result_t;

	typedef enum logic [2:0] {
		MUL_D1U_D2V,
		MUL_D2U_D1V,
		MUL_D2V_E1,
		MUL_D1V_E2,
		MUL_D1U_E2,
		MUL_D2U_E1,
		MUL_SQ
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD,
		ACC_SUB
	} acc_op_t;

	typedef struct packed {
		logic clr_step;
		logic delta_ld;
		mul_sel_t mul_sel;
		acc_op_t acc_op;
		logic det_ld;
		logic div_start;
		logic div_norm;
		logic store_face;
		logic store_norm;
		logic sqrt_start;
		logic mem_rd;
		logic sum_ld;
		logic emit;
		logic last;
		logic [1:0] axis;
		logic vb;
		logic [1:0] vtx;
		logic [1:0] corner;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic div_done;
		logic sqrt_done;
	} sts_t;

endpackage

>>> rtl/core/triangle_tangent_accumulator.sv
`timescale 1ns / 1ps
// Triangle tangent accumulator, top level.
// Depends on ttacc_pkg, ttacc_ctrl and ttacc_dp.
//
// Usage: a corner transaction is taken at a rising edge with start high and
// busy low; its fields travel on the corner struct. The first two corners of
// a face are held; busy stays low after them.
// The third corner starts the face: busy rises and the block works out the
// face tangent and bitangent, then for each of the three vertices reads its
// stored frame, adds the face vectors, renormalizes, writes it back and
// presents it on result with strobe high for exactly one cycle. The third
// result carries last_of_face and busy falls in that same cycle.
// The shared restoring divider runs 24 times per face and the square root
// unit six times.
// Results cannot be held off by the receiver; each must be taken when shown.
// After reset the vertex frame store is cleared one entry per cycle, with
// busy high.
module triangle_tangent_accumulator #(
	parameter int MAX_VERTICES = ttacc_pkg::DEF_MAX_VERTICES
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input ttacc_pkg::corner_t corner,
	output logic strobe,
	output ttacc_pkg::result_t result
);

	ttacc_pkg::cmd_t cmd;
	ttacc_pkg::sts_t sts;
	logic accept;

	assign accept = start && !busy;

	ttacc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.sts(sts),
		.cmd(cmd),
		.busy(busy)
	);

	ttacc_dp #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.corner(corner),
		.cmd(cmd),
		.sts(sts),
		.strobe(strobe),
		.result(result)
	);

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last_of_face |-> !busy)
		else $error("busy still high on the last result of a face");

	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last_of_face |-> busy)
		else $error("block idle while results of a face are pending");

	a_accept_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !strobe)
		else $error("result shown right after a corner transaction");

endmodule

>>> rtl/core/ttacc_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle: floor(num * 2^16 / den),
// saturated to 2^31-1, sign applied at the end. Uses ttacc_pkg.
module ttacc_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [64:0] num,
	input logic [63:0] den,
	input logic neg,
	output logic done,
	output logic signed [31:0] quot
);

	localparam int CW = $clog2(ttacc_pkg::DIV_STEPS);

	logic [80:0] dvd_q;
	logic [65:0] rem_q;
	logic [63:0] den_q;
	logic [30:0] quo_q;
	logic sat_q, neg_q, run_q, done_q;
	logic [CW-1:0] cnt_q;

	logic [65:0] rem_sh, rem_n;
	logic ge;
	logic [31:0] q_new;
	logic [30:0] mag;

	always_comb begin
		rem_sh = {rem_q[64:0], dvd_q[80]};
		ge = rem_sh >= {2'b00, den_q};
		rem_n = ge ? rem_sh - {2'b00, den_q} : rem_sh;
		q_new = {quo_q, ge};
		mag = sat_q ? ttacc_pkg::DELTA_LIMIT[30:0] : quo_q;
	end

	assign quot = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(ttacc_pkg::DIV_STEPS - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {num, 16'h0000};
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
			sat_q <= 1'b0;
			neg_q <= neg;
		end else if (run_q) begin
			dvd_q <= {dvd_q[79:0], 1'b0};
			rem_q <= rem_n;
			// Once the quotient passes the limit it freezes and saturates.
			if (!sat_q) begin
				if (q_new[31]) begin
					sat_q <= 1'b1;
				end else begin
					quo_q <= q_new[30:0];
				end
			end
		end
	end

endmodule

>>> rtl/core/ttacc_sqrt.sv
`timescale 1ns / 1ps
// Digit-by-digit integer square root of a 64-bit value, two radicand bits
// per cycle. Uses ttacc_pkg for the step count.
module ttacc_sqrt (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [63:0] radicand,
	output logic done,
	output logic [31:0] root
);

	localparam int CW = $clog2(ttacc_pkg::SQRT_STEPS);

	logic [63:0] x_q, r_q, bit_q;
	logic run_q, done_q;
	logic [CW-1:0] cnt_q;
	logic [63:0] trial;

	assign trial = r_q + bit_q;
	assign done = done_q;
	assign root = r_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(ttacc_pkg::SQRT_STEPS - 1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= radicand;
			r_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (run_q) begin
			if (x_q >= trial) begin
				x_q <= x_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

>>> rtl/core/ttacc_dp.sv
`timescale 1ns / 1ps
// Datapath: held corners, deltas, shared multiplier and accumulator, vertex
// frame store, divider and square root. Uses ttacc_pkg, ttacc_div, ttacc_sqrt.
module ttacc_dp #(
	parameter int MAX_VERTICES = ttacc_pkg::DEF_MAX_VERTICES
) (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input ttacc_pkg::corner_t corner,
	input ttacc_pkg::cmd_t cmd,
	output ttacc_pkg::sts_t sts,
	output logic strobe,
	output ttacc_pkg::result_t result
);

	localparam int AW = $clog2(MAX_VERTICES);

	function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] d;
		d = $signed({a[31], a}) - $signed({b[31], b});
		if (d > 33'sd2147483647) begin
			return ttacc_pkg::DELTA_LIMIT;
		end else if (d < -33'sd2147483647) begin
			return -ttacc_pkg::DELTA_LIMIT;
		end
		return d[31:0];
	endfunction

	function automatic logic signed [31:0] pick3(input logic signed [31:0] v [3],
			input logic [1:0] i);
		logic signed [31:0] r;
		unique case (i)
			2'd0: r = v[0];
			2'd1: r = v[1];
			default: r = v[2];
		endcase
		return r;
	endfunction

	function automatic logic [31:0] mag33(input logic signed [32:0] c);
		logic [32:0] t;
		t = c[32] ? ~c + 33'd1 : c;
		return t[31:0];
	endfunction

	function automatic logic [64:0] mag66(input logic signed [65:0] c);
		logic [65:0] t;
		t = c[65] ? ~c + 66'd1 : c;
		return t[64:0];
	endfunction

	// Corners.
	logic [15:0] hold_idx_q [2];
	logic signed [31:0] hold_p_q [2][3];
	logic signed [31:0] hold_u_q [2], hold_v_q [2];
	logic [15:0] cur_idx_q;
	logic signed [31:0] cur_p_q [3];
	logic signed [31:0] cur_u_q, cur_v_q;

	// Deltas and face vectors.
	logic signed [31:0] e1_q [3], e2_q [3];
	logic signed [31:0] d1u_q, d1v_q, d2u_q, d2v_q;
	logic signed [31:0] ft_q [3], fb_q [3];
	logic signed [65:0] prod_q, acc_q, det_q;
	logic degen_q;

	// Per-vertex work.
	logic signed [32:0] ct_q [3], cb_q [3];
	logic signed [15:0] ot_q [3], ob_q [3];
	logic [95:0] store_q [MAX_VERTICES];
	logic [95:0] rd_q;
	logic inside_q;
	logic [AW-1:0] clr_addr_q;
	logic strobe_q;
	ttacc_pkg::result_t res_q;

	logic [15:0] vidx;
	logic [24:0] idx_w;
	logic [AW-1:0] addr;
	logic in_range;
	logic signed [32:0] ma, mb, csel;
	logic [64:0] div_num;
	logic [64:0] det_mag;
	logic [63:0] div_den;
	logic div_neg, div_done, sqrt_done;
	logic signed [31:0] quot;
	logic [31:0] root;

	always_comb begin
		unique case (cmd.vtx)
			2'd0: vidx = hold_idx_q[0];
			2'd1: vidx = hold_idx_q[1];
			default: vidx = cur_idx_q;
		endcase
		idx_w = 25'(vidx);
		addr = idx_w[AW-1:0];
		in_range = idx_w < 25'(MAX_VERTICES);
	end

	always_comb begin
		unique case (cmd.axis)
			2'd0: csel = cmd.vb ? cb_q[0] : ct_q[0];
			2'd1: csel = cmd.vb ? cb_q[1] : ct_q[1];
			default: csel = cmd.vb ? cb_q[2] : ct_q[2];
		endcase
	end

	always_comb begin
		unique case (cmd.mul_sel)
			ttacc_pkg::MUL_D1U_D2V: begin
				ma = 33'(d1u_q);
				mb = 33'(d2v_q);
			end
			ttacc_pkg::MUL_D2U_D1V: begin
				ma = 33'(d2u_q);
				mb = 33'(d1v_q);
			end
			ttacc_pkg::MUL_D2V_E1: begin
				ma = 33'(d2v_q);
				mb = 33'(pick3(e1_q, cmd.axis));
			end
			ttacc_pkg::MUL_D1V_E2: begin
				ma = 33'(d1v_q);
				mb = 33'(pick3(e2_q, cmd.axis));
			end
			ttacc_pkg::MUL_D1U_E2: begin
				ma = 33'(d1u_q);
				mb = 33'(pick3(e2_q, cmd.axis));
			end
			ttacc_pkg::MUL_D2U_E1: begin
				ma = 33'(d2u_q);
				mb = 33'(pick3(e1_q, cmd.axis));
			end
			default: begin
				ma = $signed({1'b0, mag33(csel)});
				mb = $signed({1'b0, mag33(csel)});
			end
		endcase
	end

	always_comb begin
		det_mag = mag66(det_q);
		if (cmd.div_norm) begin
			div_num = 65'(mag33(csel));
			div_den = {30'd0, root, 2'b00};
			div_neg = csel[32];
		end else begin
			div_num = mag66(acc_q);
			div_den = det_mag[63:0];
			div_neg = acc_q[65] ^ det_q[65];
		end
	end

	ttacc_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.div_start),
		.num(div_num),
		.den(div_den),
		.neg(div_neg),
		.done(div_done),
		.quot(quot)
	);

	ttacc_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.sqrt_start),
		.radicand(acc_q[63:0]),
		.done(sqrt_done),
		.root(root)
	);

	assign sts.clr_last = clr_addr_q == AW'(MAX_VERTICES - 1);
	assign sts.div_done = div_done;
	assign sts.sqrt_done = sqrt_done;
	assign strobe = strobe_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			strobe_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (cmd.corner == 2'd2) begin
				cur_idx_q <= corner.vertex_index;
				cur_p_q[0] <= corner.pos_x;
				cur_p_q[1] <= corner.pos_y;
				cur_p_q[2] <= corner.pos_z;
				cur_u_q <= corner.tex_u;
				cur_v_q <= corner.tex_v;
			end else begin
				hold_idx_q[cmd.corner[0]] <= corner.vertex_index;
				hold_p_q[cmd.corner[0]][0] <= corner.pos_x;
				hold_p_q[cmd.corner[0]][1] <= corner.pos_y;
				hold_p_q[cmd.corner[0]][2] <= corner.pos_z;
				hold_u_q[cmd.corner[0]] <= corner.tex_u;
				hold_v_q[cmd.corner[0]] <= corner.tex_v;
			end
		end
		if (cmd.delta_ld) begin
			for (int a = 0; a < 3; a++) begin
				e1_q[a] <= sat_sub(hold_p_q[1][a], hold_p_q[0][a]);
				e2_q[a] <= sat_sub(cur_p_q[a], hold_p_q[0][a]);
			end
			d1u_q <= sat_sub(hold_u_q[1], hold_u_q[0]);
			d1v_q <= sat_sub(hold_v_q[1], hold_v_q[0]);
			d2u_q <= sat_sub(cur_u_q, hold_u_q[0]);
			d2v_q <= sat_sub(cur_v_q, hold_v_q[0]);
		end
		prod_q <= ma * mb;
		unique case (cmd.acc_op)
			ttacc_pkg::ACC_LOAD: acc_q <= prod_q;
			ttacc_pkg::ACC_ADD: acc_q <= acc_q + prod_q;
			ttacc_pkg::ACC_SUB: acc_q <= acc_q - prod_q;
			default: acc_q <= acc_q;
		endcase
		if (cmd.det_ld) begin
			det_q <= acc_q;
			degen_q <= acc_q == '0;
		end
		if (cmd.store_face && div_done) begin
			// A zero determinant contributes nothing to the vertex frames.
			for (int a = 0; a < 3; a++) begin
				if (cmd.axis == 2'(a)) begin
					if (cmd.vb) begin
						fb_q[a] <= degen_q ? '0 : quot;
					end else begin
						ft_q[a] <= degen_q ? '0 : quot;
					end
				end
			end
		end
		if (cmd.store_norm && div_done) begin
			for (int a = 0; a < 3; a++) begin
				if (cmd.axis == 2'(a)) begin
					if (cmd.vb) begin
						ob_q[a] <= (root == '0) ? '0 : quot[15:0];
					end else begin
						ot_q[a] <= (root == '0) ? '0 : quot[15:0];
					end
				end
			end
		end
		if (cmd.mem_rd) begin
			inside_q <= in_range;
		end
		if (cmd.sum_ld) begin
			// Stored Q1.14 values scale by four into Q16.16.
			for (int a = 0; a < 3; a++) begin
				ct_q[a] <= $signed({{15{rd_q[95 - 16 * a] & inside_q}},
					inside_q ? rd_q[95 - 16 * a -: 16] : 16'h0000, 2'b00})
					+ $signed({ft_q[a][31], ft_q[a]});
				cb_q[a] <= $signed({{15{rd_q[47 - 16 * a] & inside_q}},
					inside_q ? rd_q[47 - 16 * a -: 16] : 16'h0000, 2'b00})
					+ $signed({fb_q[a][31], fb_q[a]});
			end
		end
		if (cmd.emit) begin
			res_q.out_index <= vidx;
			res_q.tangent_x <= ot_q[0];
			res_q.tangent_y <= ot_q[1];
			res_q.tangent_z <= ot_q[2];
			res_q.bitangent_x <= ob_q[0];
			res_q.bitangent_y <= ob_q[1];
			res_q.bitangent_z <= ob_q[2];
			res_q.degenerate <= degen_q;
			res_q.last_of_face <= cmd.last;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			store_q[clr_addr_q] <= '0;
		end else if (cmd.emit && inside_q) begin
			store_q[addr] <= {ot_q[0], ot_q[1], ot_q[2], ob_q[0], ob_q[1], ob_q[2]};
		end
		if (cmd.mem_rd) begin
			rd_q <= store_q[addr];
		end
	end

	property p_unit_range;
		@(posedge clk) disable iff (!arst_n)
		strobe_q |-> (res_q.tangent_x <= 16'sd16384 && res_q.tangent_x >= -16'sd16384
			&& res_q.bitangent_x <= 16'sd16384 && res_q.bitangent_x >= -16'sd16384);
	endproperty
	a_unit_range: assert property (p_unit_range)
		else $error("normalized component out of unit range");

	a_emit_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> !cmd.emit)
		else $error("two results emitted back to back");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !cmd.sqrt_start && !cmd.emit)
		else $error("divider start collides with another operation");

endmodule

>>> rtl/core/ttacc_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: store clearing, corner counting and the
// per-face sequence of datapath operations. Uses ttacc_pkg.
module ttacc_ctrl (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input ttacc_pkg::sts_t sts,
	output ttacc_pkg::cmd_t cmd,
	output logic busy
);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_DELTA, S_DET0, S_DET1, S_DET2, S_DET3,
		S_NUM0, S_NUM1, S_NUM2, S_FDIV, S_FWAIT,
		S_RD, S_SUM, S_SQ0, S_SQ1, S_SQ2, S_SQ3, S_SQRT, S_SQWAIT,
		S_NDIV, S_NWAIT, S_EMIT
	} state_t;

	state_t state_q;
	logic [1:0] corner_q, axis_q, vtx_q;
	logic vb_q, busy_q;

	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			busy_q <= 1'b1;
			corner_q <= '0;
			axis_q <= '0;
			vtx_q <= '0;
			vb_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (sts.clr_last) begin
						state_q <= S_IDLE;
						busy_q <= 1'b0;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (corner_q == 2'd2) begin
							corner_q <= '0;
							state_q <= S_DELTA;
							busy_q <= 1'b1;
						end else begin
							corner_q <= corner_q + 2'd1;
						end
					end
				end
				S_DELTA: state_q <= S_DET0;
				S_DET0: state_q <= S_DET1;
				S_DET1: state_q <= S_DET2;
				S_DET2: state_q <= S_DET3;
				S_DET3: begin
					axis_q <= '0;
					vb_q <= 1'b0;
					state_q <= S_NUM0;
				end
				S_NUM0: state_q <= S_NUM1;
				S_NUM1: state_q <= S_NUM2;
				S_NUM2: state_q <= S_FDIV;
				S_FDIV: state_q <= S_FWAIT;
				S_FWAIT: begin
					if (sts.div_done) begin
						if (!vb_q) begin
							vb_q <= 1'b1;
							state_q <= S_NUM0;
						end else begin
							vb_q <= 1'b0;
							if (axis_q == 2'd2) begin
								axis_q <= '0;
								vtx_q <= '0;
								state_q <= S_RD;
							end else begin
								axis_q <= axis_q + 2'd1;
								state_q <= S_NUM0;
							end
						end
					end
				end
				S_RD: state_q <= S_SUM;
				S_SUM: state_q <= S_SQ0;
				S_SQ0: state_q <= S_SQ1;
				S_SQ1: state_q <= S_SQ2;
				S_SQ2: state_q <= S_SQ3;
				S_SQ3: state_q <= S_SQRT;
				S_SQRT: state_q <= S_SQWAIT;
				S_SQWAIT: begin
					if (sts.sqrt_done) begin
						axis_q <= '0;
						state_q <= S_NDIV;
					end
				end
				S_NDIV: state_q <= S_NWAIT;
				S_NWAIT: begin
					if (sts.div_done) begin
						if (axis_q != 2'd2) begin
							axis_q <= axis_q + 2'd1;
							state_q <= S_NDIV;
						end else begin
							axis_q <= '0;
							if (!vb_q) begin
								vb_q <= 1'b1;
								state_q <= S_SQ0;
							end else begin
								state_q <= S_EMIT;
							end
						end
					end
				end
				S_EMIT: begin
					vb_q <= 1'b0;
					if (vtx_q == 2'd2) begin
						state_q <= S_IDLE;
						busy_q <= 1'b0;
					end else begin
						vtx_q <= vtx_q + 2'd1;
						state_q <= S_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		cmd.mul_sel = ttacc_pkg::MUL_SQ;
		cmd.acc_op = ttacc_pkg::ACC_HOLD;
		cmd.axis = axis_q;
		cmd.vb = vb_q;
		cmd.vtx = vtx_q;
		cmd.corner = corner_q;
		unique case (state_q)
			S_CLEAR: cmd.clr_step = 1'b1;
			S_DELTA: cmd.delta_ld = 1'b1;
			S_DET0: cmd.mul_sel = ttacc_pkg::MUL_D1U_D2V;
			S_DET1: begin
				cmd.mul_sel = ttacc_pkg::MUL_D2U_D1V;
				cmd.acc_op = ttacc_pkg::ACC_LOAD;
			end
			S_DET2: cmd.acc_op = ttacc_pkg::ACC_SUB;
			S_DET3: cmd.det_ld = 1'b1;
			S_NUM0: cmd.mul_sel = vb_q ? ttacc_pkg::MUL_D1U_E2 : ttacc_pkg::MUL_D2V_E1;
			S_NUM1: begin
				cmd.mul_sel = vb_q ? ttacc_pkg::MUL_D2U_E1 : ttacc_pkg::MUL_D1V_E2;
				cmd.acc_op = ttacc_pkg::ACC_LOAD;
			end
			S_NUM2: cmd.acc_op = ttacc_pkg::ACC_SUB;
			S_FDIV: cmd.div_start = 1'b1;
			S_FWAIT: cmd.store_face = 1'b1;
			S_RD: cmd.mem_rd = 1'b1;
			S_SUM: cmd.sum_ld = 1'b1;
			S_SQ0: cmd.axis = 2'd0;
			S_SQ1: begin
				cmd.axis = 2'd1;
				cmd.acc_op = ttacc_pkg::ACC_LOAD;
			end
			S_SQ2: begin
				cmd.axis = 2'd2;
				cmd.acc_op = ttacc_pkg::ACC_ADD;
			end
			S_SQ3: cmd.acc_op = ttacc_pkg::ACC_ADD;
			S_SQRT: cmd.sqrt_start = 1'b1;
			S_NDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_norm = 1'b1;
			end
			S_NWAIT: begin
				cmd.div_norm = 1'b1;
				cmd.store_norm = 1'b1;
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				cmd.last = vtx_q == 2'd2;
			end
			default: cmd.clr_step = 1'b0;
		endcase
	end

endmodule
